### sv/iss_pkg.sv
// Package: shared types, codes and sizing constants for the indexed sequence store.
package iss_pkg;

    localparam int CAPACITY = 64;
    localparam int POS_W    = 7;
    localparam int COUNT_W  = 7;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int GROUP    = 8;
    localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [1:0]               cmd;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] item_value;
    } t_cmd;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [1:0]               status;
        logic [COUNT_W-1:0]       count;
    } t_result;

    // Broadcast to every cell of the row.
    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic                     rd;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctrl;

endpackage

### sv/iss_cell.sv
// One storage cell of the shifting row: holds one element and trades it with its neighbors.
module iss_cell (
    input  logic                              i_clk,
    input  logic [iss_pkg::IDX_W-1:0]         i_index,
    input  iss_pkg::t_cell_ctrl               i_ctrl,
    input  logic signed [iss_pkg::DATA_W-1:0] i_prev,
    input  logic signed [iss_pkg::DATA_W-1:0] i_next,
    output logic signed [iss_pkg::DATA_W-1:0] o_value,
    output logic signed [iss_pkg::DATA_W-1:0] o_tap
);
    import iss_pkg::*;

    logic signed [DATA_W-1:0] r_value;
    logic [CMP_W-1:0]         w_idx;
    logic [CMP_W-1:0]         w_pos;
    logic                     w_above;
    logic                     w_here;

    assign w_idx   = CMP_W'(i_index);
    assign w_pos   = CMP_W'(i_ctrl.pos);
    assign w_above = w_idx > w_pos;
    assign w_here  = w_idx == w_pos;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins) begin
            // open a slot: cells above the position take their lower neighbor
            if (w_above) begin
                r_value <= i_prev;
            end else if (w_here) begin
                r_value <= i_ctrl.value;
            end
        end else if (i_ctrl.del) begin
            // close the gap: cells from the position up take their upper neighbor
            if (w_above || w_here) begin
                r_value <= i_next;
            end
        end
    end

    assign o_value = r_value;
    assign o_tap   = (i_ctrl.rd && w_here) ? r_value : '0;

endmodule

### sv/iss_group.sv
// Registered OR of one group of cell read taps.
module iss_group (
    input  logic                              i_clk,
    input  logic signed [iss_pkg::DATA_W-1:0] i_taps [iss_pkg::GROUP],
    output logic signed [iss_pkg::DATA_W-1:0] o_sum
);
    import iss_pkg::*;

    logic signed [DATA_W-1:0] n_sum;
    logic signed [DATA_W-1:0] r_sum;

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < GROUP; k++) begin
            n_sum = n_sum | i_taps[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    assign o_sum = r_sum;

endmodule

### sv/indexed_sequence_store.sv
// Top level: ordered store of signed words in a row of shifting cells, with status and count.
// Accepts one command (insert, read or delete at a position) in every clock cycle; busy is
// never raised, so start may be held high continuously. Each command gives exactly one result,
// strobed on o_strobe once the command has passed the stage-1 and output registers; results
// come out in command order and must be taken when strobed. Every cell moves in the same
// cycle, so an insert or delete shifts the whole row at once; a read selects its cell through
// a two-level OR tree (groups of eight taps registered, then a final OR into the output
// register). There is no clearing pass after reset: only the count and the valid flags reset,
// and only entries below the count are ever read.
module indexed_sequence_store (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  iss_pkg::t_cmd    i_cmd,
    output logic             o_busy,
    output logic             o_strobe,
    output iss_pkg::t_result o_result
);
    import iss_pkg::*;

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [1:0]               n_status;
    logic                     w_accept;
    logic [CMP_W-1:0]         w_pos;
    logic [CMP_W-1:0]         w_cnt;
    t_cell_ctrl               w_ctrl;

    logic signed [DATA_W-1:0] w_cell [CAPACITY];
    logic signed [DATA_W-1:0] w_tap  [NGROUP*GROUP];
    logic signed [DATA_W-1:0] w_grp  [NGROUP];
    logic signed [DATA_W-1:0] n_read;

    logic                     r_s1_valid;
    logic [1:0]               r_s1_status;
    logic [COUNT_W-1:0]       r_s1_count;
    logic                     r_out_valid;
    t_result                  r_result;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;
    assign w_pos    = CMP_W'(i_cmd.position);
    assign w_cnt    = CMP_W'(r_count);

    always_comb begin
        n_count  = r_count;
        n_status = ST_BADPOS;
        unique case (i_cmd.cmd)
            CMD_INSERT: begin
                if (w_pos > w_cnt) begin
                    n_status = ST_BADPOS;
                end else if (r_count == CNT_W'(CAPACITY)) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_OK;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            CMD_READ: begin
                n_status = (w_pos < w_cnt) ? ST_OK : ST_BADPOS;
            end
            CMD_DELETE: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (w_pos >= w_cnt) begin
                    n_status = ST_BADPOS;
                end else begin
                    n_status = ST_OK;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = ST_BADPOS;
            end
        endcase
    end

    always_comb begin
        w_ctrl       = '0;
        w_ctrl.pos   = i_cmd.position;
        w_ctrl.value = i_cmd.item_value;
        w_ctrl.ins   = w_accept && (i_cmd.cmd == CMD_INSERT) && (n_status == ST_OK);
        w_ctrl.del   = w_accept && (i_cmd.cmd == CMD_DELETE) && (n_status == ST_OK);
        w_ctrl.rd    = w_accept && (i_cmd.cmd == CMD_READ) && (n_status == ST_OK);
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_prev;
        logic signed [DATA_W-1:0] w_next;

        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid
            assign w_prev = w_cell[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_cell[g+1];
        end

        iss_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(g)),
            .i_ctrl  (w_ctrl),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_value (w_cell[g]),
            .o_tap   (w_tap[g])
        );
    end

    for (genvar g = CAPACITY; g < NGROUP*GROUP; g++) begin : g_pad
        assign w_tap[g] = '0;
    end

    for (genvar g = 0; g < NGROUP; g++) begin : g_grp
        logic signed [DATA_W-1:0] w_in [GROUP];

        for (genvar k = 0; k < GROUP; k++) begin : g_in
            assign w_in[k] = w_tap[g*GROUP + k];
        end

        iss_group u_group (
            .i_clk  (i_clk),
            .i_taps (w_in),
            .o_sum  (w_grp[g])
        );
    end

    always_comb begin
        n_read = '0;
        for (int k = 0; k < NGROUP; k++) begin
            n_read = n_read | w_grp[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            r_s1_valid  <= w_accept;
            r_out_valid <= r_s1_valid;
        end
        r_s1_status         <= n_status;
        r_s1_count          <= COUNT_W'(n_count);
        r_result.read_value <= n_read;
        r_result.status     <= r_s1_status;
        r_result.count      <= r_s1_count;
    end

    assign o_strobe = r_out_valid;
    assign o_result = r_result;

    a_strobe_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(i_start, 2))
        else $error("result strobed without a command two cycles earlier");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_full_at_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == ST_FULL) |-> (o_result.count == COUNT_W'(CAPACITY)))
        else $error("full status while store not at capacity");

    a_read_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status != ST_OK) |-> (o_result.read_value == '0))
        else $error("nonzero read value on a refused command");

endmodule
